/* sv/fmc_pkg.sv */
// fmc_pkg: type codes, header types and the magic-number classifier
// shared by the file type classifier; depends on nothing else
package fmc_pkg;

  localparam int unsigned CNT_W     = 16;  // byte count and text window width
  localparam int unsigned MAGIC_LEN = 12;  // longest magic-number test
  localparam int unsigned LEN_W     = 4;   // holds 0..MAGIC_LEN

  typedef enum logic [4:0] {
    FT_UNKNOWN = 5'd0,
    FT_TEXT    = 5'd1,
    FT_ELF     = 5'd2,
    FT_EXE     = 5'd3,
    FT_ISO     = 5'd4,
    FT_MKV     = 5'd5,
    FT_AVI     = 5'd6,
    FT_GIF     = 5'd7,
    FT_MPG     = 5'd8,
    FT_FLAC    = 5'd9,
    FT_WAV     = 5'd10,
    FT_MP3     = 5'd11,
    FT_PDF     = 5'd12,
    FT_JPG     = 5'd13,
    FT_PNG     = 5'd14,
    FT_BMP     = 5'd15,
    FT_GZ      = 5'd16,
    FT_ZIP     = 5'd17,
    FT_RAR     = 5'd18,
    FT_BZ2     = 5'd19,
    FT_LZIP    = 5'd20,
    FT_ZLIB    = 5'd21
  } ftype_t;

  typedef logic [MAGIC_LEN-1:0][7:0] hdr_t;

  // one finished file waiting for classification
  typedef struct packed {
    hdr_t             hdr;
    logic [LEN_W-1:0] len;   // bytes seen, capped at MAGIC_LEN
    logic             high;  // non 7-bit byte inside the text window
  } snap_t;

  // priority-ordered magic-number tests, each with its own length check
  function automatic ftype_t classify(input snap_t s);
    hdr_t             h;
    logic [LEN_W-1:0] n;
    logic             riff;
    logic             jpg;
    ftype_t           ft;
    h    = s.hdr;
    n    = s.len;
    riff = (n >= LEN_W'(12)) && h[0] == 8'h52 && h[1] == 8'h49 &&
           h[2] == 8'h46 && h[3] == 8'h46;
    jpg  = (n >= LEN_W'(12)) && h[0] == 8'hff && h[1] == 8'hd8 && h[2] == 8'hff &&
           ((h[3] == 8'hdb) ||
            (h[3] == 8'he0 && h[4] == 8'h00 && h[5] == 8'h10 && h[6] == 8'h4a &&
             h[7] == 8'h46 && h[8] == 8'h49 && h[9] == 8'h46 && h[10] == 8'h00 &&
             h[11] == 8'h01) ||
            (h[3] == 8'he1 && h[6] == 8'h45 && h[7] == 8'h78 && h[8] == 8'h69 &&
             h[9] == 8'h66 && h[10] == 8'h00 && h[11] == 8'h00));
    if (n >= LEN_W'(4) && h[0] == 8'h7f && h[1] == 8'h45 && h[2] == 8'h4c &&
        h[3] == 8'h46)
      ft = FT_ELF;
    else if (n >= LEN_W'(2) && h[0] == 8'h4d && h[1] == 8'h5a)
      ft = FT_EXE;
    else if (n >= LEN_W'(5) && h[0] == 8'h43 && h[1] == 8'h44 && h[2] == 8'h30 &&
             h[3] == 8'h30 && h[4] == 8'h31)
      ft = FT_ISO;
    else if (n >= LEN_W'(4) && h[0] == 8'h1a && h[1] == 8'h45 && h[2] == 8'hdf &&
             h[3] == 8'ha3)
      ft = FT_MKV;
    else if (riff && h[8] == 8'h41 && h[9] == 8'h56 && h[10] == 8'h49 &&
             h[11] == 8'h20)
      ft = FT_AVI;
    else if (n >= LEN_W'(6) && h[0] == 8'h47 && h[1] == 8'h49 && h[2] == 8'h46 &&
             h[3] == 8'h38 && (h[4] == 8'h37 || h[4] == 8'h39) && h[5] == 8'h61)
      ft = FT_GIF;
    else if (n >= LEN_W'(4) && h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'h01 &&
             (h[3] == 8'hba || h[3] == 8'hb3))
      ft = FT_MPG;
    else if (n >= LEN_W'(4) && h[0] == 8'h66 && h[1] == 8'h4c && h[2] == 8'h61 &&
             h[3] == 8'h43)
      ft = FT_FLAC;
    else if (riff && h[8] == 8'h57 && h[9] == 8'h41 && h[10] == 8'h56 &&
             h[11] == 8'h45)
      ft = FT_WAV;
    else if (n >= LEN_W'(3) && h[0] == 8'h49 && h[1] == 8'h44 && h[2] == 8'h33)
      ft = FT_MP3;
    else if (n >= LEN_W'(4) && h[0] == 8'h25 && h[1] == 8'h50 && h[2] == 8'h44 &&
             h[3] == 8'h46)
      ft = FT_PDF;
    else if (jpg)
      ft = FT_JPG;
    else if (n >= LEN_W'(8) && h[0] == 8'h89 && h[1] == 8'h50 && h[2] == 8'h4e &&
             h[3] == 8'h47 && h[4] == 8'h0d && h[5] == 8'h0a && h[6] == 8'h1a &&
             h[7] == 8'h0a)
      ft = FT_PNG;
    else if (n >= LEN_W'(2) && h[0] == 8'h42 && h[1] == 8'h4d)
      ft = FT_BMP;
    else if (n >= LEN_W'(2) && h[0] == 8'h1f && h[1] == 8'h8b)
      ft = FT_GZ;
    else if (n >= LEN_W'(4) && h[0] == 8'h50 && h[1] == 8'h4b &&
             ((h[2] == 8'h03 && h[3] == 8'h04) || (h[2] == 8'h05 && h[3] == 8'h06) ||
              (h[2] == 8'h07 && h[3] == 8'h08)))
      ft = FT_ZIP;
    else if (n >= LEN_W'(8) && h[0] == 8'h52 && h[1] == 8'h61 && h[2] == 8'h72 &&
             h[3] == 8'h21 && h[4] == 8'h1a && h[5] == 8'h07 &&
             (h[6] == 8'h00 || (h[6] == 8'h01 && h[7] == 8'h00)))
      ft = FT_RAR;
    else if (n >= LEN_W'(3) && h[0] == 8'h42 && h[1] == 8'h5a && h[2] == 8'h68)
      ft = FT_BZ2;
    else if (n >= LEN_W'(4) && h[0] == 8'h4c && h[1] == 8'h5a && h[2] == 8'h49 &&
             h[3] == 8'h50)
      ft = FT_LZIP;
    else if (n >= LEN_W'(2) && h[0] == 8'h78 &&
             (h[1] == 8'h01 || h[1] == 8'h9c || h[1] == 8'hda))
      ft = FT_ZLIB;
    else if (s.high)
      ft = FT_UNKNOWN;
    else
      ft = FT_TEXT;
    return ft;
  endfunction

endpackage

/* sv/file_magic_classifier.sv */
// file_magic_classifier: streams a file's bytes and reports its type code
// depends on fmc_pkg for type codes, header types and the classifier
// last-marked byte -> classify stage register -> output register -> out_tvalid
// throughput: 1 byte per cycle; a new file may start right after the last byte
// the only stall is a finished result that waits in the one-deep classify stage
// while the output register is also full and not taken
// rst_n (synchronous, active low) clears count, flag, valids; text_window -> 512
module file_magic_classifier
  import fmc_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 12  // stored leading bytes, at least MAGIC_LEN (12)
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  // type code output
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] file_type, [7:5] zero
  // text window register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // text_window
);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // per-file working state
  logic [7:0]       store_r [HEADER_BYTES];  // leading bytes, no reset needed
  logic [7:0]       store_nxt [HEADER_BYTES];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic             high_r, high_nxt;
  logic             high_upd;
  logic [CNT_W-1:0] window_r;

  // classify stage and output register
  snap_t            snap_r, snap_nxt;
  logic             snap_vld_r;
  logic [4:0]       ftype_r;
  logic             out_vld_r;

  logic in_xfer;
  logic snap_adv;

  assign cfg_ready = 1'b1;

  // a finished file leaves the classify stage when the output register frees
  assign snap_adv  = snap_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !snap_vld_r || snap_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // store slot, count and text flag updated with the incoming byte
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      store_nxt[i] = (cnt_r == CNT_W'(i)) ? in_tdata : store_r[i];
    end
    cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
    high_upd = high_r || ((cnt_r < window_r) && in_tdata[7]);
    for (int i = 0; i < MAGIC_LEN; i++) begin
      snap_nxt.hdr[i] = store_nxt[i];
    end
    snap_nxt.len  = (cnt_inc >= CNT_W'(MAGIC_LEN)) ? LEN_W'(MAGIC_LEN)
                                                   : cnt_inc[LEN_W-1:0];
    snap_nxt.high = high_upd;
    // the last byte hands the file to the classify stage and starts a new one
    if (in_xfer && in_tlast) begin
      cnt_nxt  = '0;
      high_nxt = 1'b0;
    end else if (in_xfer) begin
      cnt_nxt  = cnt_inc;
      high_nxt = high_upd;
    end else begin
      cnt_nxt  = cnt_r;
      high_nxt = high_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      store_r <= store_nxt;
    end
    if (in_xfer && in_tlast) begin
      snap_r <= snap_nxt;
    end
    if (snap_adv) begin
      ftype_r <= classify(snap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      high_r     <= 1'b0;
      window_r   <= CNT_W'(512);
      snap_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      high_r <= high_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_data;
      end
      if (in_xfer && in_tlast) begin
        snap_vld_r <= 1'b1;
      end else if (snap_adv) begin
        snap_vld_r <= 1'b0;
      end
      if (snap_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, ftype_r};

`ifndef SYNTHESIS
  // a marked byte always restarts the per-file count
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> cnt_r == '0 && !high_r)
    else $error("count or flag not cleared after last byte");

  // an unmarked byte advances the count by one until saturation
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_tlast && cnt_r != CNT_MAX |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("byte count did not advance");

  // a blocked classify stage must hold off new bytes
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    snap_vld_r && out_vld_r && !out_tready |-> !in_tready)
    else $error("input accepted while classify stage is blocked");

  // a result reaches the output the cycle after leaving the classify stage
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    snap_adv |=> out_tvalid && out_tdata[4:0] <= FT_ZLIB)
    else $error("result lost or out of range");
`endif

endmodule
